### src/pla_pkg.sv
// ----------------------------------------------------------------------------
// pla_pkg: shared types and helpers of the priority lock arbiter
// Field widths, request and status codes, queue entry type, key compares.
// ----------------------------------------------------------------------------
package pla_pkg;

  localparam int unsigned QUEUE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned RANK_W = 16;
  localparam int unsigned SEQ_W  = 16;
  localparam int unsigned USER_W = 8;

  typedef enum logic [1:0] {
    FUNC_ACQUIRE = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_DISCARD = 2'd2,
    FUNC_LOCAL   = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STATUS_UNSET    = 2'd0,
    STATUS_LOW      = 2'd1,
    STATUS_HIGH     = 2'd2,
    STATUS_ACQUIRED = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ERR_OK       = 2'd0,
    ERR_MISMATCH = 2'd1,
    ERR_NOTFOUND = 2'd2,
    ERR_FULL     = 2'd3
  } err_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_POP    = 2'd3
  } cell_op_e;

  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [SEQ_W-1:0]  seqno;
    logic [USER_W-1:0] user;
    logic              high;
  } entry_t;

  typedef struct packed {
    cell_op_e op;
    logic     cmp_seq;
    entry_t   new_entry;
  } cell_ctl_t;

  // key a strictly above key b
  function automatic logic key_gt(input logic [RANK_W-1:0] ra, input logic [SEQ_W-1:0] sa,
                                  input logic [RANK_W-1:0] rb, input logic [SEQ_W-1:0] sb,
                                  input logic cmp_seq);
    logic res;
    if (ra != rb) begin
      res = (ra > rb);
    end else begin
      res = cmp_seq && (sa > sb);
    end
    return res;
  endfunction

  function automatic logic key_eq(input logic [RANK_W-1:0] ra, input logic [SEQ_W-1:0] sa,
                                  input logic [RANK_W-1:0] rb, input logic [SEQ_W-1:0] sb,
                                  input logic cmp_seq);
    return (ra == rb) && (!cmp_seq || (sa == sb));
  endfunction

endpackage

### src/priority_lock_arbiter.sv
// ----------------------------------------------------------------------------
// priority_lock_arbiter: exclusive lock with a key-ordered wait queue
// One holder plus a sorted row of queue cells; notifications leave one per
// transfer through a registered output.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in      | to block  | in_valid_i/in_stall_o  | func, group_rank, group_seqno, user_rank
//  out     | from block| out_valid_o/out_stall_i| dest_user, note_rank, note_seqno, status,
//          |           |                        | error_code, last
//  cfg     | to block  | cfg_valid_i/cfg_ready_o| cfg_data_i (compare_sequence)
//
// One request at a time: after accept, its notifications leave one by one (one for
// acquire, a queued discard and errors; up to QUEUE_DEPTH+1 for a release), each
// bounded by the single output register. A downstream stall holds the sequencer.
// Reset clears holder, queue count and config; queue cells need no reset.
// Insert and delete update all cells together: cells at or after the slot shift against a neighbor.
// ----------------------------------------------------------------------------
module priority_lock_arbiter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [1:0]                     func_i,
  input  logic [pla_pkg::RANK_W-1:0]     group_rank_i,
  input  logic [pla_pkg::SEQ_W-1:0]      group_seqno_i,
  input  logic [pla_pkg::USER_W-1:0]     user_rank_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [pla_pkg::USER_W-1:0]     dest_user_o,
  output logic [pla_pkg::RANK_W-1:0]     note_rank_o,
  output logic [pla_pkg::SEQ_W-1:0]      note_seqno_o,
  output logic [1:0]                     lock_status_o,
  output logic [1:0]                     error_code_o,
  output logic                           last_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic                           cfg_data_i
);

  localparam int unsigned DEPTH = pla_pkg::QUEUE_DEPTH;
  localparam int unsigned IDX_W = pla_pkg::IDX_W;
  localparam int unsigned CNT_W = pla_pkg::CNT_W;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EXEC   = 2'd1;
  localparam logic [1:0] ST_DEMOTE = 2'd2;
  localparam logic [1:0] ST_FINAL  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic             cmp_seq_q;
  pla_pkg::func_e   func_q;
  pla_pkg::entry_t  req_q;
  logic             holder_valid_q, holder_valid_d;
  pla_pkg::entry_t  holder_q, holder_d;
  pla_pkg::entry_t  old_q, old_d;
  logic             has_final_q, has_final_d;
  logic [IDX_W-1:0] j_q, j_d;
  logic [CNT_W-1:0] count_q, count_d;

  logic             out_valid_q;
  pla_pkg::entry_t  out_ent_q;
  logic [1:0]       out_status_q, out_err_q;
  logic             out_last_q;

  // queue row
  pla_pkg::cell_ctl_t ctl;
  pla_pkg::entry_t    cell_q [DEPTH];
  logic [DEPTH-1:0]   gt, found, first, occ, clr, high_vec;

  // emit request from the sequencer
  logic              emit;
  pla_pkg::entry_t   e_ent;
  pla_pkg::status_e  e_status;
  pla_pkg::err_e     e_err;
  logic              e_last;

  logic              slot_free;
  logic              holder_key_eq, rel_ok, more_high, nxt_high, do_grant, grant_final;
  pla_pkg::entry_t   found_ent, new_ent;
  logic [CNT_W-1:0]  jn;

  assign slot_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;

  // insert key carries its priority against the current holder
  always_comb begin
    new_ent      = req_q;
    new_ent.high = holder_valid_q &&
                   pla_pkg::key_gt(holder_q.rank, holder_q.seqno, req_q.rank, req_q.seqno,
                                   cmp_seq_q);
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    pla_pkg::entry_t left, right;
    logic            pgt, pfound;
    if (i == 0) begin : g_head
      assign left   = new_ent;
      assign pgt    = 1'b0;
      assign pfound = 1'b0;
    end else begin : g_body
      assign left   = cell_q[i-1];
      assign pgt    = gt[i-1];
      assign pfound = found[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign right = cell_q[i];
    end else begin : g_mid
      assign right = cell_q[i+1];
    end
    assign occ[i]      = (CNT_W'(i) < count_q);
    assign high_vec[i] = cell_q[i].high;

    pla_cell u_cell (
      .clk_i        (clk_i),
      .ctl_i        (ctl),
      .occupied_i   (occ[i]),
      .clr_high_i   (clr[i]),
      .left_i       (left),
      .right_i      (right),
      .prev_gt_i    (pgt),
      .prev_found_i (pfound),
      .entry_o      (cell_q[i]),
      .gt_o         (gt[i]),
      .found_o      (found[i]),
      .first_o      (first[i])
    );
  end

  // pick the first matching entry for a discard
  always_comb begin
    found_ent = '0;
    for (int k = 0; k < DEPTH; k++) begin
      found_ent = found_ent | (cell_q[k] & {$bits(pla_pkg::entry_t){first[k]}});
    end
  end

  assign holder_key_eq = holder_valid_q &&
                         pla_pkg::key_eq(req_q.rank, req_q.seqno, holder_q.rank,
                                         holder_q.seqno, cmp_seq_q);
  assign rel_ok    = holder_key_eq && (holder_q.user == req_q.user);
  assign more_high = (count_q >= CNT_W'(2)) && cell_q[1].high;
  assign jn        = CNT_W'(j_q) + CNT_W'(1);
  assign nxt_high  = (jn < count_q) && high_vec[jn[IDX_W-1:0]];

  always_comb begin
    state_d        = state_q;
    holder_valid_d = holder_valid_q;
    holder_d       = holder_q;
    old_d          = old_q;
    has_final_d    = has_final_q;
    j_d            = j_q;
    count_d        = count_q;
    ctl.op         = pla_pkg::OP_HOLD;
    ctl.cmp_seq    = cmp_seq_q;
    ctl.new_entry  = new_ent;
    clr            = '0;
    emit           = 1'b0;
    e_ent          = req_q;
    e_status       = pla_pkg::STATUS_UNSET;
    e_err          = pla_pkg::ERR_OK;
    e_last         = 1'b1;
    do_grant       = 1'b0;
    grant_final    = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (slot_free) begin
          state_d = ST_IDLE;
          priority if (func_q == pla_pkg::FUNC_ACQUIRE) begin
            emit = 1'b1;
            if (!holder_valid_q) begin
              holder_valid_d = 1'b1;
              holder_d       = req_q;
              e_status       = pla_pkg::STATUS_ACQUIRED;
            end else if (count_q == CNT_W'(DEPTH)) begin
              e_err = pla_pkg::ERR_FULL;
            end else begin
              ctl.op   = pla_pkg::OP_INSERT;
              count_d  = count_q + CNT_W'(1);
              e_status = new_ent.high ? pla_pkg::STATUS_HIGH : pla_pkg::STATUS_LOW;
            end
          end else if (func_q == pla_pkg::FUNC_RELEASE ||
                       (func_q == pla_pkg::FUNC_DISCARD && holder_key_eq)) begin
            if (!rel_ok) begin
              emit  = 1'b1;
              e_err = pla_pkg::ERR_MISMATCH;
            end else begin
              old_d          = holder_q;
              holder_valid_d = 1'b0;
              has_final_d    = 1'b1;
              do_grant       = 1'b1;
              grant_final    = 1'b1;
            end
          end else if (func_q == pla_pkg::FUNC_DISCARD) begin
            emit = 1'b1;
            if (found[DEPTH-1]) begin
              e_ent   = found_ent;
              ctl.op  = pla_pkg::OP_DELETE;
              count_d = count_q - CNT_W'(1);
            end else begin
              e_err = pla_pkg::ERR_NOTFOUND;
            end
          end else begin
            holder_valid_d = 1'b0;
            has_final_d    = 1'b0;
            do_grant       = 1'b1;
          end

          // hand the lock to the queue head, then demote and notify
          if (do_grant) begin
            if (count_q != '0) begin
              emit           = 1'b1;
              e_ent          = cell_q[0];
              e_status       = pla_pkg::STATUS_ACQUIRED;
              e_last         = !grant_final && !more_high;
              holder_valid_d = 1'b1;
              holder_d       = cell_q[0];
              ctl.op         = pla_pkg::OP_POP;
              count_d        = count_q - CNT_W'(1);
              j_d            = '0;
              if (more_high) begin
                state_d = ST_DEMOTE;
              end else if (grant_final) begin
                state_d = ST_FINAL;
              end
            end else if (grant_final) begin
              state_d = ST_FINAL;
            end
          end
        end
      end
      ST_DEMOTE: begin
        if (slot_free) begin
          emit       = 1'b1;
          e_ent      = cell_q[j_q];
          e_status   = pla_pkg::STATUS_LOW;
          e_last     = !has_final_q && !nxt_high;
          clr[j_q]   = 1'b1;
          if (nxt_high) begin
            j_d = jn[IDX_W-1:0];
          end else if (has_final_q) begin
            state_d = ST_FINAL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_FINAL: begin
        if (slot_free) begin
          emit    = 1'b1;
          e_ent   = old_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      cmp_seq_q      <= 1'b0;
      holder_valid_q <= 1'b0;
      holder_q       <= '0;
      has_final_q    <= 1'b0;
      j_q            <= '0;
      count_q        <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      holder_valid_q <= holder_valid_d;
      holder_q       <= holder_d;
      has_final_q    <= has_final_d;
      j_q            <= j_d;
      count_q        <= count_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cmp_seq_q <= cfg_data_i;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    old_q <= old_d;
    if (in_valid_i && !in_stall_o) begin
      func_q        <= pla_pkg::func_e'(func_i);
      req_q.rank    <= group_rank_i;
      req_q.seqno   <= group_seqno_i;
      req_q.user    <= user_rank_i;
      req_q.high    <= 1'b0;
    end
    if (emit) begin
      out_ent_q    <= e_ent;
      out_status_q <= e_status;
      out_err_q    <= e_err;
      out_last_q   <= e_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign dest_user_o   = out_ent_q.user;
  assign note_rank_o   = out_ent_q.rank;
  assign note_seqno_o  = out_ent_q.seqno;
  assign lock_status_o = out_status_q;
  assign error_code_o  = out_err_q;
  assign last_o        = out_last_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("queue count above depth");

  a_demote_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DEMOTE) |-> (high_vec[j_q] && holder_valid_q && occ[j_q]))
    else $error("demotion on an entry that is not a queued high entry");

  a_no_emit_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |-> !emit)
    else $error("notification issued into a stalled output");

  a_final_has_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINAL) |-> has_final_q)
    else $error("final notification without a released holder");

endmodule

### src/pla_cell.sv
// ----------------------------------------------------------------------------
// pla_cell: one slot of the sorted wait queue
// Holds one entry, compares it with the incoming key and shifts with neighbors.
// ----------------------------------------------------------------------------
module pla_cell (
  input  logic                clk_i,
  input  pla_pkg::cell_ctl_t  ctl_i,
  input  logic                occupied_i,
  input  logic                clr_high_i,
  input  pla_pkg::entry_t     left_i,
  input  pla_pkg::entry_t     right_i,
  input  logic                prev_gt_i,
  input  logic                prev_found_i,
  output pla_pkg::entry_t     entry_o,
  output logic                gt_o,
  output logic                found_o,
  output logic                first_o
);

  pla_pkg::entry_t entry_q, entry_d;
  logic            match;

  assign gt_o = !occupied_i ||
                pla_pkg::key_gt(entry_q.rank, entry_q.seqno, ctl_i.new_entry.rank,
                                ctl_i.new_entry.seqno, ctl_i.cmp_seq);
  assign match = occupied_i &&
                 pla_pkg::key_eq(entry_q.rank, entry_q.seqno, ctl_i.new_entry.rank,
                                 ctl_i.new_entry.seqno, ctl_i.cmp_seq);
  assign found_o = prev_found_i || match;
  assign first_o = match && !prev_found_i;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    unique case (ctl_i.op)
      pla_pkg::OP_HOLD:   entry_d = entry_q;
      pla_pkg::OP_INSERT: begin
        // everything at or after the slot moves one place right
        if (prev_gt_i) begin
          entry_d = left_i;
        end else if (gt_o) begin
          entry_d = ctl_i.new_entry;
        end
      end
      pla_pkg::OP_DELETE: begin
        if (found_o) begin
          entry_d = right_i;
        end
      end
      pla_pkg::OP_POP:    entry_d = right_i;
      default:            entry_d = entry_q;
    endcase
    if (clr_high_i) begin
      entry_d.high = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule
